### rtl/fwe_pkg.sv
// fwe_pkg: beat types, request and register codes, and the shared MAC
// request type for the FIR plus windowed energy block. No dependencies.
package fwe_pkg;

	// operand width of the second multiplier stage
	localparam int MUL_W = 33;

	// request types
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_KERNEL = 2'd1;
	localparam logic [1:0] REQ_WINDOW = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_KERNEL_LENGTH = 2'd0;
	localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;
	localparam logic [1:0] CFG_KERNEL_RECIP  = 2'd2;

	localparam logic [7:0]  KERNEL_LENGTH_RST = 8'd1;
	localparam logic [8:0]  WINDOW_LENGTH_RST = 9'd256;
	localparam logic [16:0] KERNEL_RECIP_RST  = 17'd65536;
	localparam logic [16:0] RECIP_MAX         = 17'd65536;

	// shared MAC operations
	localparam logic [1:0] OP_FIR      = 2'd0;
	localparam logic [1:0] OP_ENERGY   = 2'd1;
	localparam logic [1:0] OP_SCALE_LO = 2'd2;
	localparam logic [1:0] OP_SCALE_HI = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] sample_value;
		logic               first_of_stream;
		logic [7:0]         tap_index;
		logic signed [15:0] tap_value;
	} in_item_t;

	typedef struct packed {
		logic [39:0] energy_value;
		logic [31:0] energy_index;
	} out_item_t;

	typedef struct packed {
		logic                    valid;
		logic [1:0]              op;
		logic signed [15:0]      x;
		logic signed [15:0]      y;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mac_req_t;

endpackage

### rtl/fwe_ram.sv
// fwe_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
module fwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/fwe_mac.sv
// fwe_mac: shared two-stage multiplier with accumulators for the FIR sum,
// the reciprocal scaling and the energy sum. Depends on fwe_pkg.
module fwe_mac #(
	parameter int ACC_W = 40,
	parameter int SCL_W = 58
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fwe_pkg::mac_req_t       req,
	input  logic                    clr,
	output logic                    busy,
	output logic signed [ACC_W-1:0] fir_acc,
	output logic signed [SCL_W-1:0] scl_acc,
	output logic [39:0]             en_acc
);
	import fwe_pkg::*;

	logic                      v_s1, v_s2;
	logic [1:0]                op_s1, op_s2;
	logic signed [31:0]        p_next, p_s1;
	logic signed [MUL_W-1:0]   a_s1, b_s1, ma, mb;
	logic signed [2*MUL_W-1:0] q_next, q_s2;
	logic [61:0]               sq_rnd;
	logic [31:0]               en_term;
	logic signed [SCL_W-1:0]   scl_term;
	logic signed [ACC_W-1:0]   fir_acc_q;
	logic signed [SCL_W-1:0]   scl_acc_q;
	logic [39:0]               en_acc_q;

	assign p_next = $signed(req.x) * $signed(req.y);

	// stage two operands: square for energy, pass-through for FIR taps, a and b for scaling
	always_comb begin
		unique case (op_s1) inside
			OP_FIR: begin
				ma = MUL_W'(p_s1);
				mb = {{(MUL_W-1){1'b0}}, 1'b1};
			end
			OP_ENERGY: begin
				ma = MUL_W'(p_s1);
				mb = MUL_W'(p_s1);
			end
			OP_SCALE_LO, OP_SCALE_HI: begin
				ma = a_s1;
				mb = b_s1;
			end
		endcase
	end

	assign q_next = ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			op_s1 <= OP_FIR;
			op_s2 <= OP_FIR;
		end else begin
			v_s1  <= req.valid;
			v_s2  <= v_s1;
			op_s1 <= req.op;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= p_next;
		a_s1 <= req.a;
		b_s1 <= req.b;
		q_s2 <= q_next;
	end

	// squared product rounded to Q2.30
	assign sq_rnd  = q_s2[61:0] + 62'(2**29);
	assign en_term = sq_rnd[61:30];

	always_comb begin
		if (op_s2 == OP_SCALE_HI) begin
			scl_term = $signed({q_s2[SCL_W-33:0], 32'b0});
		end else begin
			scl_term = $signed(q_s2[SCL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			fir_acc_q <= '0;
			scl_acc_q <= '0;
			en_acc_q  <= '0;
		end else if (v_s2) begin
			unique case (op_s2) inside
				OP_FIR:                   fir_acc_q <= fir_acc_q + $signed(q_s2[ACC_W-1:0]);
				OP_ENERGY:                en_acc_q  <= en_acc_q + {8'b0, en_term};
				OP_SCALE_LO, OP_SCALE_HI: scl_acc_q <= scl_acc_q + scl_term;
			endcase
		end
	end

	assign busy    = v_s1 | v_s2;
	assign fir_acc = fir_acc_q;
	assign scl_acc = scl_acc_q;
	assign en_acc  = en_acc_q;

endmodule

### rtl/fir_then_windowed_energy.sv
// fir_then_windowed_energy: top level, sequencer, line stores and tap tables.
// Depends on fwe_pkg, fwe_ram and fwe_mac.
//
// Centred FIR filter followed by a windowed energy envelope, one sample per
// input beat. Load beats (req_type kernel or window) write one tap each and
// the block stays ready. A sample beat drops ready and runs through one
// shared multiply-accumulate unit: K FIR taps, low and high reciprocal
// scaling, the push into the filtered line and W window taps, with a pipeline
// drain after each MAC pass and the result load last; then ready returns.
// Window taps and result are skipped while the window is not yet full, and
// every MAC pass while the kernel is still filling. The MAC takes one tap per
// cycle, limited by the single read port of each line and tap memory. A
// finished result waits in the output register while the next beats are
// taken. Line stores need no clearing pass: the sample line is only read over
// samples written since the stream start, and the filtered line uses a fill
// count so that entries older than the stream read as zero. Tap tables hold
// whatever was loaded; reading an unloaded tap gives an undefined result.
module fir_then_windowed_energy #(
	parameter int MAX_KERNEL_TAPS = 128,
	parameter int MAX_WINDOW_TAPS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fwe_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output fwe_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import fwe_pkg::*;

	// address widths of the tap tables and circular lines
	localparam int KAW   = (MAX_KERNEL_TAPS > 1) ? $clog2(MAX_KERNEL_TAPS) : 1;
	localparam int WAW   = (MAX_WINDOW_TAPS > 1) ? $clog2(MAX_WINDOW_TAPS) : 1;
	// widths that hold a length itself
	localparam int KCW   = $clog2(MAX_KERNEL_TAPS + 1);
	localparam int WCW   = $clog2(MAX_WINDOW_TAPS + 1);
	localparam int CW    = (KCW > WCW) ? KCW : WCW;
	// FIR sum: 2^30 per tap at most, signed
	localparam int ACC_W = 32 + KCW;
	// FIR sum times a 17-bit reciprocal
	localparam int SCL_W = ACC_W + 18;

	localparam logic [3:0] ST_IDLE        = 4'd0;
	localparam logic [3:0] ST_CHECK       = 4'd1;
	localparam logic [3:0] ST_FIR         = 4'd2;
	localparam logic [3:0] ST_FIR_DRAIN   = 4'd3;
	localparam logic [3:0] ST_SCALE_LO    = 4'd4;
	localparam logic [3:0] ST_SCALE_HI    = 4'd5;
	localparam logic [3:0] ST_SCALE_DRAIN = 4'd6;
	localparam logic [3:0] ST_PUSH        = 4'd7;
	localparam logic [3:0] ST_ENERGY      = 4'd8;
	localparam logic [3:0] ST_EN_DRAIN    = 4'd9;
	localparam logic [3:0] ST_EMIT        = 4'd10;

	logic [3:0]               state_q;
	logic [7:0]               kernel_length_q;
	logic [8:0]               window_length_q;
	logic [16:0]              kernel_recip_q;

	logic [KCW-1:0]           k_len, k_off;
	logic [WCW-1:0]           w_len, w_off;
	logic [16:0]              recip;

	logic [31:0]              count_q, n_q, j_q, m_q;
	logic [KAW-1:0]           sptr_q;
	logic [WAW-1:0]           fptr_q;
	logic [WCW-1:0]           fcount_q;
	logic [CW-1:0]            idx_q;

	logic                     rd_v_q, rd_live_q, live;
	logic [1:0]               rd_op_q;
	logic                     fir_last, en_last;

	logic                     accept, is_sample;
	logic                     krn_we, win_we, smp_we, flt_we;
	logic [KAW-1:0]           smp_raddr, krn_raddr;
	logic [WAW-1:0]           flt_raddr, win_raddr;
	logic [15:0]              smp_rdata, krn_rdata, flt_rdata, win_rdata;

	mac_req_t                 mac_req;
	logic                     mac_busy;
	logic signed [ACC_W-1:0]  fir_acc;
	logic signed [ACC_W-33:0] acc_hi;
	logic signed [SCL_W-1:0]  scl_acc, scl_rnd;
	logic signed [SCL_W-32:0] scl_sh;
	logic                     scl_fits;
	logic [15:0]              filt_val;
	logic [39:0]              en_acc;

	logic                     out_valid_q;
	out_item_t                out_item_q;

	// ---------------------------------------------------------------
	// Effective lengths: zero acts as one, overlong saturates.
	// ---------------------------------------------------------------
	always_comb begin
		if (kernel_length_q == '0) begin
			k_len = KCW'(1);
		end else if (32'(kernel_length_q) > 32'(MAX_KERNEL_TAPS)) begin
			k_len = KCW'(MAX_KERNEL_TAPS);
		end else begin
			k_len = KCW'(kernel_length_q);
		end
		if (window_length_q == '0) begin
			w_len = WCW'(1);
		end else if (32'(window_length_q) > 32'(MAX_WINDOW_TAPS)) begin
			w_len = WCW'(MAX_WINDOW_TAPS);
		end else begin
			w_len = WCW'(window_length_q);
		end
	end

	// centre offsets: j = n - (K-1-K/2), m = j - (W-1-W/2)
	assign k_off = k_len - KCW'(1) - (k_len >> 1);
	assign w_off = w_len - WCW'(1) - (w_len >> 1);
	assign recip = (kernel_recip_q > RECIP_MAX) ? RECIP_MAX : kernel_recip_q;

	// ---------------------------------------------------------------
	// Handshakes and memory writes. Taps and samples are written on the
	// accepting edge.
	// ---------------------------------------------------------------
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign is_sample = (in_item.req_type == REQ_SAMPLE);

	assign smp_we = accept && is_sample;
	assign krn_we = accept && (in_item.req_type == REQ_KERNEL)
		&& (32'(in_item.tap_index) < 32'(MAX_KERNEL_TAPS));
	assign win_we = accept && (in_item.req_type == REQ_WINDOW)
		&& (32'(in_item.tap_index) < 32'(MAX_WINDOW_TAPS));
	assign flt_we = (state_q == ST_PUSH);

	// Lines are circular: the newest entry sits just below the pointer, so
	// tap i of an L-tap pass reads pointer - L + i.
	assign smp_raddr = sptr_q - KAW'(k_len) + KAW'(idx_q);
	assign krn_raddr = KAW'(idx_q);
	assign flt_raddr = fptr_q - WAW'(w_len) + WAW'(idx_q);
	assign win_raddr = WAW'(idx_q);

	// filtered entry of age W-1-i exists only if that many were pushed
	assign live     = (CW'(w_len) - CW'(1) - idx_q) < CW'(fcount_q);
	assign fir_last = (idx_q == CW'(k_len) - CW'(1));
	assign en_last  = (idx_q == CW'(w_len) - CW'(1));

	fwe_ram #(.WIDTH(16), .DEPTH(2**KAW)) u_smp_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (sptr_q),
		.wdata (in_item.sample_value),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

	fwe_ram #(.WIDTH(16), .DEPTH(MAX_KERNEL_TAPS)) u_krn_ram (
		.clk   (clk),
		.we    (krn_we),
		.waddr (KAW'(in_item.tap_index)),
		.wdata (in_item.tap_value),
		.raddr (krn_raddr),
		.rdata (krn_rdata)
	);

	fwe_ram #(.WIDTH(16), .DEPTH(2**WAW)) u_flt_ram (
		.clk   (clk),
		.we    (flt_we),
		.waddr (fptr_q),
		.wdata (filt_val),
		.raddr (flt_raddr),
		.rdata (flt_rdata)
	);

	fwe_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW_TAPS)) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (WAW'(in_item.tap_index)),
		.wdata (in_item.tap_value),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	// ---------------------------------------------------------------
	// Shared MAC. Tap beats arrive in the cycle after the read address;
	// scaling splits the FIR sum into a low unsigned word and a signed
	// high part so each product stays within 33 by 33 bits.
	// ---------------------------------------------------------------
	assign acc_hi = fir_acc[ACC_W-1:32];

	always_comb begin
		mac_req = '0;
		if (state_q == ST_SCALE_LO) begin
			mac_req.valid = 1'b1;
			mac_req.op    = OP_SCALE_LO;
			mac_req.a     = {1'b0, fir_acc[31:0]};
			mac_req.b     = {{(MUL_W-17){1'b0}}, recip};
		end else if (state_q == ST_SCALE_HI) begin
			mac_req.valid = 1'b1;
			mac_req.op    = OP_SCALE_HI;
			mac_req.a     = MUL_W'(acc_hi);
			mac_req.b     = {{(MUL_W-17){1'b0}}, recip};
		end else begin
			mac_req.valid = rd_v_q;
			mac_req.op    = rd_op_q;
			if (rd_op_q == OP_FIR) begin
				mac_req.x = smp_rdata;
				mac_req.y = krn_rdata;
			end else begin
				mac_req.x = rd_live_q ? flt_rdata : 16'h0000;
				mac_req.y = win_rdata;
			end
		end
	end

	fwe_mac #(.ACC_W(ACC_W), .SCL_W(SCL_W)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mac_req),
		.clr     (state_q == ST_CHECK),
		.busy    (mac_busy),
		.fir_acc (fir_acc),
		.scl_acc (scl_acc),
		.en_acc  (en_acc)
	);

	// round half up, floor shift by 31, saturate to Q1.15
	assign scl_rnd  = scl_acc + SCL_W'(2**30);
	assign scl_sh   = scl_rnd[SCL_W-1:31];
	assign scl_fits = (&scl_sh[SCL_W-32:15]) | ~(|scl_sh[SCL_W-32:15]);
	assign filt_val = scl_fits ? scl_sh[15:0]
		: (scl_sh[SCL_W-32] ? 16'h8000 : 16'h7FFF);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			kernel_length_q <= KERNEL_LENGTH_RST;
			window_length_q <= WINDOW_LENGTH_RST;
			kernel_recip_q  <= KERNEL_RECIP_RST;
			count_q         <= '0;
			sptr_q          <= '0;
			fptr_q          <= '0;
			fcount_q        <= '0;
			idx_q           <= '0;
			rd_v_q          <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			rd_v_q <= (state_q == ST_FIR) || (state_q == ST_ENERGY);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_KERNEL_LENGTH: kernel_length_q <= cfg_data[7:0];
					CFG_WINDOW_LENGTH: window_length_q <= cfg_data[8:0];
					CFG_KERNEL_RECIP:  kernel_recip_q  <= cfg_data;
					default: ;
				endcase
			end

			// output register: load a finished result, or free on a taken beat
			if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_sample) begin
						sptr_q <= sptr_q + KAW'(1);
						if (in_item.first_of_stream) begin
							count_q  <= 32'd1;
							fcount_q <= '0;
						end else begin
							count_q <= count_q + 32'd1;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					idx_q <= '0;
					// kernel full once K samples exist
					if (n_q >= 32'(k_len) - 32'd1) begin
						state_q <= ST_FIR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIR: begin
					idx_q <= idx_q + CW'(1);
					if (fir_last) begin
						state_q <= ST_FIR_DRAIN;
					end
				end
				ST_FIR_DRAIN: begin
					if (!rd_v_q && !mac_busy) begin
						state_q <= ST_SCALE_LO;
					end
				end
				ST_SCALE_LO: state_q <= ST_SCALE_HI;
				ST_SCALE_HI: state_q <= ST_SCALE_DRAIN;
				ST_SCALE_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					fptr_q <= fptr_q + WAW'(1);
					if (fcount_q != WCW'(MAX_WINDOW_TAPS)) begin
						fcount_q <= fcount_q + WCW'(1);
					end
					idx_q <= '0;
					if (j_q >= 32'(w_len) - 32'd1) begin
						state_q <= ST_ENERGY;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ENERGY: begin
					idx_q <= idx_q + CW'(1);
					if (en_last) begin
						state_q <= ST_EN_DRAIN;
					end
				end
				ST_EN_DRAIN: begin
					if (!rd_v_q && !mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && is_sample) begin
			n_q <= in_item.first_of_stream ? 32'd0 : count_q;
		end
		if (state_q == ST_CHECK) begin
			j_q <= n_q - 32'(k_off);
		end
		if (state_q == ST_PUSH) begin
			m_q <= j_q - 32'(w_off);
		end
		rd_live_q <= live;
		rd_op_q   <= (state_q == ST_ENERGY) ? OP_ENERGY : OP_FIR;
		if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
			out_item_q.energy_value <= en_acc;
			out_item_q.energy_index <= m_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### rtl/fwe_checker.sv
// fwe_checker: port-level assertions for fir_then_windowed_energy, bound to
// the top level below. Depends on fwe_pkg.
module fwe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input fwe_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input fwe_pkg::out_item_t out_item
);
	import fwe_pkg::*;

	// a sample beat always starts a busy sequence
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.req_type == REQ_SAMPLE) |=> !in_ready)
		else $error("ready stayed high after a sample beat");

	// tap loads and unknown requests never stall the input
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.req_type != REQ_SAMPLE) |=> in_ready)
		else $error("ready dropped after a non-sample beat");

	// a new result only appears at the end of a busy sequence
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("output beat changed while stalled");

endmodule

bind fir_then_windowed_energy fwe_checker u_fwe_checker (.*);

### tb/fwe_energy_check.sv
// fwe_energy_check: watches the sample, result and register channels of
// fir_then_windowed_energy, predicts each energy beat and compares it.
// Depends on fwe_pkg.
module fwe_energy_check #(
	parameter int MAX_KERNEL_TAPS = 128,
	parameter int MAX_WINDOW_TAPS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  fwe_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  fwe_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output int                 errors,
	output int                 waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import fwe_pkg::*;

	logic signed [15:0] raw_line [MAX_KERNEL_TAPS];
	logic signed [15:0] fir_line [MAX_WINDOW_TAPS];
	logic signed [15:0] kern [MAX_KERNEL_TAPS];
	logic signed [15:0] win [MAX_WINDOW_TAPS];
	logic [31:0]        next_index;
	logic [7:0]         k_reg;
	logic [8:0]         w_reg;
	logic [16:0]        recip_reg;
	out_item_t          energy_due [$];
	out_item_t          head;

	// zero means one, oversize means the table size
	function automatic int eff_len(int v, int maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic logic signed [15:0] filter_point(int k);
		longint acc;
		longint recip;
		longint scaled;
		acc = 0;
		recip = (recip_reg > RECIP_MAX) ? RECIP_MAX : recip_reg;
		for (int i = 0; i < k; i++)
			acc += longint'(raw_line[k-1-i]) * longint'(kern[i]);
		// round to nearest, ties up, then saturate to Q1.15
		scaled = (acc * recip + (longint'(1) << 30)) >>> 31;
		if (scaled > 32767)
			return 16'sh7fff;
		if (scaled < -32768)
			return 16'sh8000;
		return scaled[15:0];
	endfunction

	function automatic logic [39:0] envelope_point(int w);
		longint            p;
		longint unsigned   a;
		logic [63:0]       sum;
		sum = '0;
		for (int i = 0; i < w; i++) begin
			p = longint'(fir_line[w-1-i]) * longint'(win[i]);
			a = (p < 0) ? -p : p;
			sum += (a * a + (64'd1 << 29)) >> 30;
		end
		return sum[39:0];
	endfunction

	task automatic take_item(in_item_t it);
		int              k;
		int              w;
		longint unsigned n;
		longint unsigned j;
		longint unsigned m;
		out_item_t       due;
		case (it.req_type)
			REQ_KERNEL: begin
				if (it.tap_index < MAX_KERNEL_TAPS)
					kern[it.tap_index] = it.tap_value;
			end
			REQ_WINDOW: begin
				if (it.tap_index < MAX_WINDOW_TAPS)
					win[it.tap_index] = it.tap_value;
			end
			REQ_SAMPLE: begin
				if (it.first_of_stream) begin
					for (int i = 0; i < MAX_KERNEL_TAPS; i++)
						raw_line[i] = '0;
					for (int i = 0; i < MAX_WINDOW_TAPS; i++)
						fir_line[i] = '0;
					next_index = '0;
				end
				k = eff_len(k_reg, MAX_KERNEL_TAPS);
				w = eff_len(w_reg, MAX_WINDOW_TAPS);
				n = next_index;
				next_index = next_index + 32'd1;
				for (int i = MAX_KERNEL_TAPS - 1; i > 0; i--)
					raw_line[i] = raw_line[i-1];
				raw_line[0] = it.sample_value;
				if (n + 1 >= k) begin
					j = n - (k - 1) + k / 2;
					for (int i = MAX_WINDOW_TAPS - 1; i > 0; i--)
						fir_line[i] = fir_line[i-1];
					fir_line[0] = filter_point(k);
					if (j + 1 >= w) begin
						m = j - (w - 1) + w / 2;
						due.energy_value = envelope_point(w);
						due.energy_index = m[31:0];
						energy_due = {energy_due, due};
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_KERNEL_TAPS; i++) begin
				raw_line[i] = '0;
				kern[i] = '0;
			end
			for (int i = 0; i < MAX_WINDOW_TAPS; i++) begin
				fir_line[i] = '0;
				win[i] = '0;
			end
			next_index = '0;
			k_reg = KERNEL_LENGTH_RST;
			w_reg = WINDOW_LENGTH_RST;
			recip_reg = KERNEL_RECIP_RST;
			energy_due.delete();
			errors = 0;
		end else begin
			// result first: a beat accepted on this edge cannot be answered on it
			if (out_valid && out_ready) begin
				if (energy_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got value %0d index %0d",
						$time, out_item.energy_value, out_item.energy_index);
				end else begin
					head = energy_due.pop_front();
					if (out_item.energy_value !== head.energy_value) begin
						errors++;
						$display("%0t: energy_value expected %0d, got %0d",
							$time, head.energy_value, out_item.energy_value);
					end
					if (out_item.energy_index !== head.energy_index) begin
						errors++;
						$display("%0t: energy_index expected %0d, got %0d",
							$time, head.energy_index, out_item.energy_index);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KERNEL_LENGTH: k_reg = cfg_data[7:0];
					CFG_WINDOW_LENGTH: w_reg = cfg_data[8:0];
					CFG_KERNEL_RECIP:  recip_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_item(in_item);
		end
		waiting = energy_due.size();
	end

endmodule

### tb/tb_fir_then_windowed_energy.sv
// tb_fir_then_windowed_energy: stimulus and verdict for the FIR plus windowed
// energy block; prediction and comparison live in fwe_energy_check.
// Depends on fwe_pkg, fir_then_windowed_energy and fwe_energy_check.
module tb_fir_then_windowed_energy;
	timeunit 1ns;
	timeprecision 1ps;
	import fwe_pkg::*;

	localparam int KERNEL_TAPS    = 128;
	localparam int WINDOW_TAPS    = 256;
	localparam int STALL_MAX      = 12;
	// covers a full MAC pass at the largest lengths, with some margin
	localparam int DRAIN_CYCLES   = 420;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// random phases: lengths, reciprocal, beat count, restart rate per mille,
	// and whether both sides run without idling
	localparam int NUM_PHASES = 9;
	localparam int PH_K     [NUM_PHASES] = '{1, 0, 3, 7, 4, 16, 128, 255, 1};
	localparam int PH_W     [NUM_PHASES] = '{1, 0, 5, 2, 8, 32, 256, 511, 256};
	localparam int PH_R     [NUM_PHASES] = '{65536, 131071, 21845, 9362, 16384, 4096,
		512, 0, 65536};
	localparam int PH_N     [NUM_PHASES] = '{150, 80, 180, 150, 180, 150, 80, 60, 70};
	localparam int PH_FIRST [NUM_PHASES] = '{20, 10, 10, 30, 0, 0, 0, 0, 0};
	localparam bit PH_CALM  [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 0, 0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_KERNEL_LENGTH;
	logic [16:0] cfg_data = '0;

	int errors;
	int waiting;
	bit calm = 1'b0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	fir_then_windowed_energy #(
		.MAX_KERNEL_TAPS(KERNEL_TAPS),
		.MAX_WINDOW_TAPS(WINDOW_TAPS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	fwe_energy_check #(
		.MAX_KERNEL_TAPS(KERNEL_TAPS),
		.MAX_WINDOW_TAPS(WINDOW_TAPS)
	) i_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.waiting  (waiting)
	);

	// Watchdog: any beat on any channel restarts the count. The longest
	// legitimate quiet stretch is the drain hold before a register write.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: a fresh stall before every beat, none in calm phases.
	initial begin : energy_sink
		int stall;
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic in_item_t beat_of(logic [1:0] req, logic signed [15:0] sample,
		logic first, logic [7:0] idx, logic signed [15:0] tap);
		in_item_t it;
		it.req_type = req;
		it.sample_value = sample;
		it.first_of_stream = first;
		it.tap_index = idx;
		it.tap_value = tap;
		return it;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		if ($urandom_range(0, 15) != 0)
			return 16'($urandom);
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'sh0001;
			default: return 16'shffff;
		endcase
	endfunction

	// Mostly samples with random content; a sprinkling of tap reloads (some
	// off the end of the kernel table) and unknown requests as noise.
	function automatic in_item_t random_beat(int first_pm);
		in_item_t it;
		int       pick;
		it = beat_of(REQ_SAMPLE, pick_sample(), ($urandom_range(0, 999) < first_pm),
			8'($urandom), 16'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 6)
			it.req_type = REQ_KERNEL;
		else if (pick < 12)
			it.req_type = REQ_WINDOW;
		else if (pick < 14)
			it.req_type = REQ_UNKNOWN;
		if (it.req_type != REQ_SAMPLE)
			it.first_of_stream = 1'($urandom);
		return it;
	endfunction

	// Called on a rising edge; returns on the edge that takes the beat.
	// Valid is only dropped when a gap is drawn, so back-to-back beats never
	// see valid lowered and raised in one step.
	task automatic send(in_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait for every predicted energy beat to come out.
	// The count is looked at on the falling edge, clear of checker updates.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers only change with the block idle: drain, then let a sample
	// that made no result finish its MAC pass.
	task automatic configure(int k, int w, int r);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_KERNEL_LENGTH, 17'(k));
		write_reg(CFG_WINDOW_LENGTH, 17'(w));
		write_reg(CFG_KERNEL_RECIP, 17'(r));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both tap tables first: no sample may ever read an unloaded tap.
		for (int i = 0; i < KERNEL_TAPS; i++)
			send(beat_of(REQ_KERNEL, 16'($urandom), 1'($urandom), 8'(i), 16'($urandom)));
		for (int i = 0; i < WINDOW_TAPS; i++)
			send(beat_of(REQ_WINDOW, 16'($urandom), 1'($urandom), 8'(i), 16'($urandom)));

		// Directed: single taps so full-scale products show up directly.
		configure(1, 1, 65536);
		// start flag on a load must not restart the stream
		send(beat_of(REQ_KERNEL, 16'sh0000, 1'b1, 8'd0, 16'sh8000));
		send(beat_of(REQ_WINDOW, 16'sh7fff, 1'b1, 8'd0, 16'sh7fff));
		// kernel loads past the table are dropped
		send(beat_of(REQ_KERNEL, 16'sh1234, 1'b0, 8'd200, 16'sh5555));
		send(beat_of(REQ_KERNEL, 16'sh0000, 1'b0, 8'd255, 16'sh7fff));
		// unknown request: no result, no restart
		send(beat_of(REQ_UNKNOWN, 16'sh7fff, 1'b1, 8'd0, 16'sh7fff));
		// minus one times minus one saturates the filter output
		send(beat_of(REQ_SAMPLE, 16'sh8000, 1'b1, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh7fff, 1'b0, 8'hff, 16'shffff));
		send(beat_of(REQ_SAMPLE, 16'sh0000, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh0001, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'shffff, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh4000, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh7fff, 1'b1, 8'd0, 16'sh0000));
		// top entry of the window table
		send(beat_of(REQ_WINDOW, 16'sh0000, 1'b0, 8'd255, 16'sh8000));

		// zero lengths act as one; reciprocal above one clamps
		configure(0, 0, 131071);
		send(beat_of(REQ_SAMPLE, 16'sh8000, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh7fff, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'shffff, 1'b0, 8'd0, 16'sh0000));

		// oversize lengths clamp to the tables; the lines keep their contents
		configure(255, 511, 0);
		send(beat_of(REQ_SAMPLE, 16'sh7fff, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh8000, 1'b0, 8'd0, 16'sh0000));
		send(beat_of(REQ_SAMPLE, 16'sh0001, 1'b0, 8'd0, 16'sh0000));

		// Random phases. Late phases carry no restarts so the count has long
		// passed the fill point when the largest windows come in.
		for (int p = 0; p < NUM_PHASES; p++) begin
			configure(PH_K[p], PH_W[p], PH_R[p]);
			calm = PH_CALM[p];
			for (int i = 0; i < PH_N[p]; i++) begin
				// hold off mid-phase until the output side has caught up
				if (i == PH_N[p] / 2)
					drain();
				send(random_beat(PH_FIRST[p]));
			end
		end
		calm = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && waiting == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/fwe_pkg.sv
rtl/fwe_ram.sv
rtl/fwe_mac.sv
rtl/fir_then_windowed_energy.sv
rtl/fwe_checker.sv
tb/fwe_energy_check.sv
tb/tb_fir_then_windowed_energy.sv
